>>> rtl/core/bmdf_pkg.sv
`timescale 1ns / 1ps

package bmdf_pkg;

  // request codes
  localparam logic CMD_ADVERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // beam kinds (the remaining code is treated as not a beam)
  localparam logic [1:0] BEAM_NONE    = 2'd0;
  localparam logic [1:0] BEAM_NAME    = 2'd1;
  localparam logic [1:0] BEAM_SERVICE = 2'd2;

  // beam format constants
  localparam logic [63:0] ZERO_TEXT_ID     = 64'h3030_3030_3030_3030;
  localparam logic [7:0]  NAME_BEAM_LEN    = 8'd16;
  localparam logic [7:0]  SERVICE_BEAM_LEN = 8'd13;
  localparam logic [7:0]  DIGIT_ZERO       = 8'd48;
  localparam logic [7:0]  SHAPE_NONE       = 8'd255;

  // classified request from front to back
  typedef struct packed {
    logic        cmd;
    logic        ok;
    logic [7:0]  shape;
    logic [63:0] id;
  } req_t;

  // result item
  typedef struct packed {
    logic       accepted;
    logic       message_ready;
    logic [7:0] shape_code;
  } res_t;

endpackage

>>> rtl/core/bmdf_ram.sv
`timescale 1ns / 1ps

module bmdf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/bmdf_fifo.sv
`timescale 1ns / 1ps

module bmdf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/bmdf_front.sv
`timescale 1ns / 1ps

module bmdf_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             command,
  input  logic [1:0]       beam_kind,
  input  logic [7:0]       content_length,
  input  logic [63:0]      msg_id,
  input  logic [7:0]       name_last_char,
  input  logic             req_pop,
  output logic             req_empty,
  output bmdf_pkg::req_t   req_data
);

  bmdf_pkg::req_t req_in;
  logic           name_ok;
  logic           service_ok;
  logic [7:0]     name_shape;

  // beam format checks
  assign name_ok = (beam_kind == bmdf_pkg::BEAM_NAME)
                && (content_length == bmdf_pkg::NAME_BEAM_LEN)
                && (msg_id != bmdf_pkg::ZERO_TEXT_ID);
  assign service_ok = (beam_kind == bmdf_pkg::BEAM_SERVICE)
                   && (content_length == bmdf_pkg::SERVICE_BEAM_LEN);

  // shape from the last name character, SHAPE_NONE below the digit zero
  assign name_shape = (name_last_char < bmdf_pkg::DIGIT_ZERO) ? bmdf_pkg::SHAPE_NONE
                    : name_last_char - bmdf_pkg::DIGIT_ZERO;

  // classified request
  always_comb begin
    req_in.cmd   = command;
    req_in.ok    = name_ok || service_ok;
    req_in.shape = name_ok ? name_shape : msg_id[63:56];
    req_in.id    = msg_id;
  end

  // request queue toward the back end
  bmdf_fifo #(
    .WIDTH ($bits(bmdf_pkg::req_t)),
    .DEPTH (2)
  ) u_req_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (req_in),
    .full  (full),
    .pop   (req_pop),
    .rdata (req_data),
    .empty (req_empty)
  );

endmodule

>>> rtl/core/bmdf_back.sv
`timescale 1ns / 1ps

module bmdf_back #(
  parameter int HISTORY_DEPTH = 32,
  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_empty,
  input  bmdf_pkg::req_t   req_data,
  output logic             req_pop,
  input  logic             res_full,
  output logic             res_push,
  output bmdf_pkg::res_t   res_data,
  output logic             ram_rd_en,
  output logic [IDX_W-1:0] ram_rd_addr,
  input  logic [63:0]      ram_rd_data,
  output logic             ram_wr_en,
  output logic [IDX_W-1:0] ram_wr_addr,
  output logic [63:0]      ram_wr_data
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t                   state;
  logic [IDX_W-1:0]         scan_idx;
  logic [IDX_W-1:0]         cmp_idx;
  logic                     cmp_live;
  logic [63:0]              cur_id;
  logic [7:0]               cur_shape;
  logic [HISTORY_DEPTH-1:0] entry_valid;
  logic [IDX_W-1:0]         newest_slot;
  logic                     message_pending;
  logic [7:0]               pending_shape;
  logic                     hit;
  logic                     scan_last;
  logic [IDX_W-1:0]         slot_new;

  // take a request only when the result queue has room for its result
  assign req_pop = (state == ST_IDLE) && !req_empty && !res_full && !res_push;

  // history walk, one entry per cycle
  assign ram_rd_en   = (state == ST_SCAN);
  assign ram_rd_addr = scan_idx;

  // compare the entry read in the previous cycle
  assign hit       = cmp_live && entry_valid[cmp_idx] && (ram_rd_data == cur_id);
  assign scan_last = (cmp_idx == IDX_W'(HISTORY_DEPTH - 1));
  assign slot_new  = (newest_slot == '0) ? IDX_W'(HISTORY_DEPTH - 1) : newest_slot - 1'b1;

  // sequencer, history bookkeeping and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      cmp_live        <= 1'b0;
      entry_valid     <= '0;
      newest_slot     <= '0;
      message_pending <= 1'b0;
      pending_shape   <= '0;
      res_push        <= 1'b0;
      ram_wr_en       <= 1'b0;
    end else begin
      res_push  <= 1'b0;
      ram_wr_en <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (req_pop) begin
            if (req_data.cmd == bmdf_pkg::CMD_READ) begin
              res_push               <= 1'b1;
              res_data.accepted      <= 1'b0;
              res_data.message_ready <= message_pending;
              res_data.shape_code    <= message_pending ? pending_shape : '0;
              message_pending        <= 1'b0;
            end else if (!req_data.ok) begin
              res_push <= 1'b1;
              res_data <= '0;
            end else begin
              cur_id    <= req_data.id;
              cur_shape <= req_data.shape;
              scan_idx  <= '0;
              cmp_live  <= 1'b0;
              state     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (hit) begin
            // duplicate, state unchanged
            res_push <= 1'b1;
            res_data <= '0;
            state    <= ST_IDLE;
          end else if (cmp_live && scan_last) begin
            // new id: insert at the front of the ring
            ram_wr_en              <= 1'b1;
            ram_wr_addr            <= slot_new;
            ram_wr_data            <= cur_id;
            entry_valid[slot_new]  <= 1'b1;
            newest_slot            <= slot_new;
            message_pending        <= 1'b1;
            pending_shape          <= cur_shape;
            res_push               <= 1'b1;
            res_data.accepted      <= 1'b1;
            res_data.message_ready <= 1'b0;
            res_data.shape_code    <= '0;
            state                  <= ST_IDLE;
          end else begin
            scan_idx <= (scan_idx == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : scan_idx + 1'b1;
            cmp_idx  <= scan_idx;
            cmp_live <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // the result queue always has room when a result is pushed
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  // an accepted result always comes with the history write
  a_accept_writes: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_data.accepted) |-> ram_wr_en)
    else $error("accepted result without history insert");

  // a written entry is marked valid
  a_write_valid: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> entry_valid[ram_wr_addr])
    else $error("history entry written but not valid");

  // one result per request, never two in a row
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    res_push |=> !res_push)
    else $error("back-to-back result pushes");
`endif

endmodule

>>> rtl/core/beacon_message_dedup_filter.sv
`timescale 1ns / 1ps

// Duplicate filter for beacon advertisements. Each request gives exactly one
// result. A read command or a malformed beam is answered straight from the
// idle state of the back end. A well-formed beam walks the whole id history,
// one entry per cycle through the registered read port of the history RAM;
// a duplicate ends the walk early at its matching entry. Two-deep request and
// result queues sit on either side of the back end, so push is still taken
// while a result waits for pop, until the request queue fills.
module beacon_message_dedup_filter #(
  parameter int HISTORY_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        command,
  input  logic [1:0]  beam_kind,
  input  logic [7:0]  content_length,
  input  logic [63:0] msg_id,
  input  logic [7:0]  name_last_char,
  output logic        empty,
  input  logic        pop,
  output logic        accepted,
  output logic        message_ready,
  output logic [7:0]  shape_code
);

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  bmdf_pkg::req_t   req_data;
  logic             req_pop;
  logic             req_empty;
  bmdf_pkg::res_t   res_in;
  bmdf_pkg::res_t   res_out;
  logic             res_push;
  logic             res_full;
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  logic [63:0]      ram_rd_data;
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  logic [63:0]      ram_wr_data;

  // accept and classify
  bmdf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .command        (command),
    .beam_kind      (beam_kind),
    .content_length (content_length),
    .msg_id         (msg_id),
    .name_last_char (name_last_char),
    .req_pop        (req_pop),
    .req_empty      (req_empty),
    .req_data       (req_data)
  );

  // history search, insert and pending message
  bmdf_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .req_empty   (req_empty),
    .req_data    (req_data),
    .req_pop     (req_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_data    (res_in),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data)
  );

  // id history
  bmdf_ram #(
    .WIDTH (64),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // result queue
  bmdf_fifo #(
    .WIDTH ($bits(bmdf_pkg::res_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign accepted      = res_out.accepted;
  assign message_ready = res_out.message_ready;
  assign shape_code    = res_out.shape_code;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // kind code that the block treats as not a beam
  localparam logic [1:0] BEAM_UNUSED = 2'd3;
  localparam int RING_SIZE = 32;
  localparam int RANDOM_REQUESTS = 1850;
  localparam int SETTLE_CYCLES = 48;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        command = bmdf_pkg::CMD_ADVERT;
  logic [1:0]  beam_kind = bmdf_pkg::BEAM_NONE;
  logic [7:0]  content_length = 8'd0;
  logic [63:0] msg_id = 64'd0;
  logic [7:0]  name_last_char = 8'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic        accepted;
  logic        message_ready;
  logic [7:0]  shape_code;

  // predictor state: recency ring of seen ids and the latched message
  logic [63:0] recent_ids [RING_SIZE];
  logic        slot_used [RING_SIZE];
  logic [4:0]  ring_head;
  logic        msg_waiting;
  logic [7:0]  held_shape;

  // verdicts still owed by the block, oldest first
  bmdf_pkg::res_t due_verdicts [$];
  bmdf_pkg::res_t front_verdict;

  // run statistics
  int sent_count = 0;
  int checked_count = 0;
  int recorded_count = 0;
  int dup_count = 0;
  int delivered_count = 0;
  int mismatches = 0;

  // when set, neither side inserts gaps
  logic steady = 1'b0;
  int   pop_hold = 0;

  beacon_message_dedup_filter u_top (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .command        (command),
    .beam_kind      (beam_kind),
    .content_length (content_length),
    .msg_id         (msg_id),
    .name_last_char (name_last_char),
    .empty          (empty),
    .pop            (pop),
    .accepted       (accepted),
    .message_ready  (message_ready),
    .shape_code     (shape_code)
  );

  always #5 clk = ~clk;

  // give up if the run hangs
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // expected result of one request, advancing the predictor state
  function automatic bmdf_pkg::res_t judge_request(input logic cmd, input logic [1:0] kind,
                                                   input logic [7:0] len,
                                                   input logic [63:0] id,
                                                   input logic [7:0] last_char);
    bmdf_pkg::res_t r;
    logic           well_formed;
    logic           seen;
    logic [7:0]     shape;
    r = '0;
    well_formed = 1'b0;
    seen = 1'b0;
    shape = 8'd0;
    if (cmd == bmdf_pkg::CMD_READ) begin
      if (msg_waiting) begin
        r.message_ready = 1'b1;
        r.shape_code = held_shape;
        msg_waiting = 1'b0;
        delivered_count++;
      end
    end else begin
      if (kind == bmdf_pkg::BEAM_NAME && len == bmdf_pkg::NAME_BEAM_LEN
          && id != bmdf_pkg::ZERO_TEXT_ID) begin
        well_formed = 1'b1;
        shape = (last_char < bmdf_pkg::DIGIT_ZERO) ? bmdf_pkg::SHAPE_NONE
              : last_char - bmdf_pkg::DIGIT_ZERO;
      end else if (kind == bmdf_pkg::BEAM_SERVICE && len == bmdf_pkg::SERVICE_BEAM_LEN) begin
        well_formed = 1'b1;
        shape = id[63:56];
      end
      for (int k = 0; k < RING_SIZE; k++) begin
        if (slot_used[k] && recent_ids[k] == id) seen = 1'b1;
      end
      if (well_formed && !seen) begin
        // newest entry moves back one slot, wrapping at the ring size
        ring_head = ring_head - 5'd1;
        recent_ids[ring_head] = id;
        slot_used[ring_head] = 1'b1;
        held_shape = shape;
        msg_waiting = 1'b1;
        r.accepted = 1'b1;
        recorded_count++;
      end else if (well_formed) begin
        dup_count++;
      end
    end
    return r;
  endfunction

  // drive one request and wait until it is taken
  task automatic send_req(input logic cmd, input logic [1:0] kind, input logic [7:0] len,
                          input logic [63:0] id, input logic [7:0] last_char);
    int gap;
    @(negedge clk);
    push = 1'b1;
    command = cmd;
    beam_kind = kind;
    content_length = len;
    msg_id = id;
    name_last_char = last_char;
    @(posedge clk);
    while (full) @(posedge clk);
    due_verdicts.push_back(judge_request(cmd, kind, len, id, last_char));
    sent_count++;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      push = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_read();
    send_req(bmdf_pkg::CMD_READ, 2'($urandom_range(0, 3)), 8'($urandom),
             {$urandom, $urandom}, 8'($urandom));
  endtask

  // result side: random stalls on pop
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop = 1'b0;
      pop_hold--;
    end else begin
      pop = 1'b1;
      if ($urandom_range(0, 2) == 0) pop_hold = gap_len();
    end
  end

  // compare each delivered result with the oldest verdict
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      checked_count++;
      if (due_verdicts.size() == 0) begin
        $error("result with no request waiting");
        mismatches++;
      end else begin
        front_verdict = due_verdicts.pop_front();
        if (accepted !== front_verdict.accepted) begin
          $error("accepted: expected %0d, actual %0d", front_verdict.accepted, accepted);
          mismatches++;
        end
        if (message_ready !== front_verdict.message_ready) begin
          $error("message_ready: expected %0d, actual %0d",
                 front_verdict.message_ready, message_ready);
          mismatches++;
        end
        if (shape_code !== front_verdict.shape_code) begin
          $error("shape_code: expected %0d, actual %0d", front_verdict.shape_code,
                 shape_code);
          mismatches++;
        end
      end
    end
  end

  // reads on nothing and every kind of malformed beam
  task automatic test_reads_and_rejects();
    send_read();
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_NAME, bmdf_pkg::NAME_BEAM_LEN,
             bmdf_pkg::ZERO_TEXT_ID, 8'h35);
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_NAME, 8'd15,
             64'hA5A5_0000_1234_5678, 8'h35);
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_SERVICE, 8'd12,
             64'hA5A5_0000_1234_5678, 8'h35);
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_NONE, bmdf_pkg::NAME_BEAM_LEN,
             64'hA5A5_0000_1234_5678, 8'h35);
    send_req(bmdf_pkg::CMD_ADVERT, BEAM_UNUSED, bmdf_pkg::SERVICE_BEAM_LEN,
             64'hA5A5_0000_1234_5678, 8'h35);
    send_read();
  endtask

  // shape extremes for both beam kinds, plus an unread message being replaced
  task automatic test_shape_codes();
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_NAME, bmdf_pkg::NAME_BEAM_LEN,
             64'd0, bmdf_pkg::DIGIT_ZERO);
    send_read();
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_NAME, bmdf_pkg::NAME_BEAM_LEN,
             64'd1, bmdf_pkg::DIGIT_ZERO - 8'd1);
    send_read();
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_NAME, bmdf_pkg::NAME_BEAM_LEN,
             64'd2, 8'hFF);
    send_read();
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_NAME, bmdf_pkg::NAME_BEAM_LEN,
             64'd3, 8'h00);
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_SERVICE, bmdf_pkg::SERVICE_BEAM_LEN,
             64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_SERVICE, bmdf_pkg::SERVICE_BEAM_LEN,
             64'h00FF_FFFF_FFFF_FFFF, 8'hFF);
    send_read();
    send_read();
  endtask

  // seen ids are dropped whatever beam kind carries them
  task automatic test_duplicates();
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_SERVICE, bmdf_pkg::SERVICE_BEAM_LEN,
             64'd0, 8'h31);
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_NAME, bmdf_pkg::NAME_BEAM_LEN,
             64'hFFFF_FFFF_FFFF_FFFF, 8'h39);
    send_read();
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_NAME, bmdf_pkg::NAME_BEAM_LEN,
             64'h3131_3131_3131_3131, 8'h39);
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_NAME, bmdf_pkg::NAME_BEAM_LEN,
             64'h3131_3131_3131_3131, 8'h39);
    send_read();
  endtask

  // fill the ring, then check that the oldest id falls out
  task automatic test_ring_eviction();
    logic [63:0] fresh [RING_SIZE + 1];
    for (int i = 0; i <= RING_SIZE; i++) fresh[i] = {$urandom, $urandom};
    for (int i = 0; i < RING_SIZE; i++) begin
      if (i % 2 == 0)
        send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_SERVICE, bmdf_pkg::SERVICE_BEAM_LEN,
                 fresh[i], 8'($urandom));
      else
        send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_NAME, bmdf_pkg::NAME_BEAM_LEN,
                 fresh[i], 8'($urandom));
    end
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_SERVICE, bmdf_pkg::SERVICE_BEAM_LEN,
             fresh[0], 8'($urandom));
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_SERVICE, bmdf_pkg::SERVICE_BEAM_LEN,
             fresh[RING_SIZE], 8'($urandom));
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_SERVICE, bmdf_pkg::SERVICE_BEAM_LEN,
             fresh[0], 8'($urandom));
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_NAME, bmdf_pkg::NAME_BEAM_LEN,
             fresh[1], 8'($urandom));
    send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_NAME, bmdf_pkg::NAME_BEAM_LEN,
             fresh[RING_SIZE - 1], 8'($urandom));
    send_read();
  endtask

  // mostly well-formed beams over a small id pool, with reads and noise
  task automatic test_random_traffic();
    logic [63:0] id_pool [$];
    logic [63:0] id;
    logic [7:0]  last_char;
    logic [7:0]  len;
    logic [1:0]  kind;
    int          r;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      steady = ((i / 150) % 4 == 3);
      r = $urandom_range(0, 99);
      // favor digits and below-digit codes for the name shape
      case ($urandom_range(0, 3))
        0: last_char = 8'($urandom_range(48, 57));
        1: last_char = 8'($urandom_range(0, 47));
        default: last_char = 8'($urandom);
      endcase
      if (id_pool.size() > 0 && $urandom_range(0, 2) == 0)
        id = id_pool[$urandom_range(0, id_pool.size() - 1)];
      else
        id = {$urandom, $urandom};
      if (r < 25) begin
        send_read();
      end else if (r < 75) begin
        if ($urandom_range(0, 1) == 0) begin
          if ($urandom_range(0, 29) == 0) id = bmdf_pkg::ZERO_TEXT_ID;
          send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_NAME, bmdf_pkg::NAME_BEAM_LEN,
                   id, last_char);
        end else begin
          send_req(bmdf_pkg::CMD_ADVERT, bmdf_pkg::BEAM_SERVICE, bmdf_pkg::SERVICE_BEAM_LEN,
                   id, last_char);
        end
        id_pool.push_back(id);
        if (id_pool.size() > 48) void'(id_pool.pop_front());
      end else begin
        kind = 2'($urandom_range(0, 3));
        len = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(12, 17)) : 8'($urandom);
        send_req(bmdf_pkg::CMD_ADVERT, kind, len, id, last_char);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    ring_head = 5'd0;
    msg_waiting = 1'b0;
    held_shape = 8'd0;
    for (int k = 0; k < RING_SIZE; k++) slot_used[k] = 1'b0;

    // synchronous reset, released at a falling clock edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reads_and_rejects();
    test_shape_codes();
    test_duplicates();
    test_ring_eviction();
    test_random_traffic();

    // drain outstanding results, then watch for strays
    @(negedge clk);
    push = 1'b0;
    while (due_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d new messages recorded, %0d duplicate beams dropped",
             sent_count, recorded_count, dup_count);
    $display("%0d reads returned a message, %0d results checked, %0d mismatches",
             delivered_count, checked_count, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
